// ===== rtl/b58enc_pkg.sv =====
// Shared types, constants and lookup functions for the base-58 block encoder.
// No dependencies; every other file refers to this package by scoped names.
package b58enc_pkg;

  localparam int BYTE_W      = 8;
  localparam int SYM_W       = 7;
  localparam int DIGIT_W     = 6;
  localparam int DIGITS      = 11;
  localparam int BLOCK_BYTES = 8;
  localparam int STEPS       = 4;   // doublings per cycle (one nibble)
  localparam int IDX_W       = $clog2(DIGITS);
  localparam int CNT_W       = $clog2(BLOCK_BYTES);

  // a digit at or above half the radix overflows when doubled
  localparam logic [DIGIT_W-1:0] HALF_RADIX = DIGIT_W'(58 / 2);

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // base-58 digit to ASCII character
  function automatic logic [SYM_W-1:0] b58_char(input digit_t d);
    logic [SYM_W-1:0] dx;
    logic [SYM_W-1:0] ch;
    dx = {1'b0, d};
    priority if (dx < 7'd9) begin
      ch = 7'h31 + dx;
    end else if (dx < 7'd17) begin
      ch = 7'h41 + (dx - 7'd9);
    end else if (dx < 7'd22) begin
      ch = 7'h4A + (dx - 7'd17);
    end else if (dx < 7'd33) begin
      ch = 7'h50 + (dx - 7'd22);
    end else if (dx < 7'd44) begin
      ch = 7'h61 + (dx - 7'd33);
    end else begin
      ch = 7'h6D + (dx - 7'd44);
    end
    return ch;
  endfunction

  // characters emitted for a block of n bytes, minus one
  function automatic logic [IDX_W-1:0] chars_m1(input logic [CNT_W:0] n);
    logic [IDX_W-1:0] r;
    unique case (n)
      4'd1:    r = 4'd1;
      4'd2:    r = 4'd2;
      4'd3:    r = 4'd4;
      4'd4:    r = 4'd5;
      4'd5:    r = 4'd6;
      4'd6:    r = 4'd8;
      4'd7:    r = 4'd9;
      4'd8:    r = 4'd10;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/b58enc_if.sv =====
// Valid/ready channel interfaces for the byte input and the character output.
// Depends on b58enc_pkg for field widths.
interface b58enc_in_if;
  logic                           valid;
  logic                           ready;
  logic [b58enc_pkg::BYTE_W-1:0]  data_byte;
  logic                           message_end;

  modport source (output valid, data_byte, message_end, input ready);
  modport sink   (input valid, data_byte, message_end, output ready);
endinterface

interface b58enc_out_if;
  logic                           valid;
  logic                           ready;
  logic [b58enc_pkg::SYM_W-1:0]   symbol;
  logic                           run_last;
  logic                           message_done;

  modport source (output valid, symbol, run_last, message_done, input ready);
  modport sink   (input valid, symbol, run_last, message_done, output ready);
endinterface

// ===== rtl/base58_block_encoder_core.sv =====
// Block base-58 encoder top level: byte input channel, character output.
// Depends on b58enc_pkg, b58enc_if, b58enc_cell and b58enc_out.
//
// in_ch carries one message byte per beat, message_end marks the last byte.
// out_ch carries one base-58 character per beat, most significant first;
// run_last flags the last character of a block, message_done the last one
// of the message. Eight bytes give 11 characters; a short final block of
// n bytes gives 2, 3, 5, 6, 7, 9 or 10 characters, left-padded with '1'.
// The block value is held as 11 base-58 digits in a row of cells; each
// byte is shifted in a nibble per cycle, high nibble first, and the
// cell chain sets the byte rate. in_ch.ready is high only while the chain is
// idle. After the byte that closes a block, ST_LOW shifts its low nibble,
// then ST_EMIT loads the first character into the output register, then one
// character per cycle follows while out_ch.ready stays high.
// A stall on out_ch holds the current character and pauses emission; the
// byte after a block is accepted while the last character still waits.
// Synchronous reset clears the digits, the byte count and the output valid.
module base58_block_encoder_core (
  input  logic           clk,
  input  logic           rst_n,
  b58enc_in_if.sink      in_ch,
  b58enc_out_if.source   out_ch
);

  localparam int DIGITS = b58enc_pkg::DIGITS;
  localparam int STEPS  = b58enc_pkg::STEPS;
  localparam int IDX_W  = b58enc_pkg::IDX_W;
  localparam int CNT_W  = b58enc_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOW  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [STEPS-1:0]  low_r;
  logic              end_r;

  logic                                  accept;
  logic [STEPS-1:0]                      nib;
  logic [CNT_W:0]                        n_bytes;
  b58enc_pkg::cell_ctl_t                 ctl;
  logic [DIGITS:0][STEPS-1:0]            carry;
  logic [DIGITS-1:0][b58enc_pkg::DIGIT_W-1:0] digit_w;
  logic                                  load;
  logic                                  can_load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign n_bytes     = {1'b0, cnt_r} + 4'd1;
  assign load        = (state_r == ST_EMIT) && can_load;

  // high nibble on the accepting cycle, low nibble next; MSB first
  assign nib = (state_r == ST_IDLE) ? in_ch.data_byte[7:4] : low_r;

  for (genvar s = 0; s < STEPS; s++) begin : g_nib
    assign carry[0][s] = nib[STEPS-1-s];
  end

  always_comb begin
    ctl.shift = accept || (state_r == ST_LOW);
    ctl.clear = load && (idx_r == '0);
  end

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    b58enc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .cin   (carry[i]),
      .cout  (carry[i+1]),
      .digit (digit_w[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOW;
        end
      end
      ST_LOW: begin
        if (n_bytes == 4'(b58enc_pkg::BLOCK_BYTES) || end_r) begin
          state_nxt = ST_EMIT;
          idx_nxt   = b58enc_pkg::chars_m1(n_bytes);
        end else begin
          state_nxt = ST_IDLE;
          cnt_nxt   = n_bytes[CNT_W-1:0];
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
            cnt_nxt   = '0;
          end else begin
            idx_nxt = idx_r - 4'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // hold the low nibble and end mark of the byte being absorbed
  always_ff @(posedge clk) begin
    if (accept) begin
      low_r <= in_ch.data_byte[3:0];
      end_r <= in_ch.message_end;
    end
  end

  b58enc_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_ch   (out_ch),
    .load     (load),
    .digit    (digit_w[idx_r]),
    .last     (idx_r == '0),
    .done     ((idx_r == '0) && end_r),
    .can_load (can_load)
  );

`ifndef ASSERT_OFF
  a_no_top_carry: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift |-> (carry[DIGITS] == '0))
    else $error("base-58 digit row overflowed");

  a_clear_after_block: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (digit_w == '0))
    else $error("digits not cleared after block");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (idx_r < 4'(DIGITS)))
    else $error("character index out of range");

  a_low_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOW) |=> (state_r != ST_LOW))
    else $error("low nibble shifted twice");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.message_done) |-> out_ch.run_last)
    else $error("message_done without run_last");
`endif

endmodule

// ===== rtl/b58enc_cell.sv =====
// One base-58 digit cell: doubles its digit STEPS times per shift cycle,
// taking carries from its lower neighbor. Depends on b58enc_pkg.
module b58enc_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  b58enc_pkg::cell_ctl_t           ctl,
  input  logic [b58enc_pkg::STEPS-1:0]    cin,
  output logic [b58enc_pkg::STEPS-1:0]    cout,
  output b58enc_pkg::digit_t              digit
);

  b58enc_pkg::digit_t                                 digit_r;
  logic [b58enc_pkg::STEPS:0][b58enc_pkg::DIGIT_W-1:0] stage;

  // carry out of the first doubling depends only on this digit; later ones also take the lower neighbor's carry in
  always_comb begin
    stage[0] = digit_r;
    for (int s = 0; s < b58enc_pkg::STEPS; s++) begin
      cout[s]    = (stage[s] >= b58enc_pkg::HALF_RADIX);
      stage[s+1] = {5'(stage[s] - (cout[s] ? b58enc_pkg::HALF_RADIX : 6'd0)), cin[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      digit_r <= '0;
    end else if (ctl.shift) begin
      digit_r <= stage[b58enc_pkg::STEPS];
    end
  end

  assign digit = digit_r;

endmodule

// ===== rtl/b58enc_out.sv =====
// Output register for the character channel: maps a digit to its character
// and holds the beat until taken. Depends on b58enc_pkg and b58enc_out_if.
module b58enc_out (
  input  logic                 clk,
  input  logic                 rst_n,
  b58enc_out_if.source         out_ch,
  input  logic                 load,
  input  b58enc_pkg::digit_t   digit,
  input  logic                 last,
  input  logic                 done,
  output logic                 can_load
);

  logic                          valid_r;
  logic [b58enc_pkg::SYM_W-1:0]  symbol_r;
  logic                          last_r;
  logic                          done_r;

  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      symbol_r <= b58enc_pkg::b58_char(digit);
      last_r   <= last;
      done_r   <= done;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.symbol       = symbol_r;
  assign out_ch.run_last     = last_r;
  assign out_ch.message_done = done_r;

endmodule
